// ===== src/dd_pkg.sv =====
// Shared types and constants for the double door passage classifier.
// Used by dd_track, the top level and the checker; depends on nothing.
package dd_pkg;

  // Per-door tracking state.
  typedef enum logic [1:0] {
    ST_CLOSED   = 2'd0,
    ST_OPEN     = 2'd1,
    ST_WAS_OPEN = 2'd2
  } door_status_e;

  // Which door won a first-opened or first-closed race.
  typedef enum logic [1:0] {
    WHO_NONE  = 2'd0,
    WHO_OUTER = 2'd1,
    WHO_INNER = 2'd2
  } door_who_e;

  // Passage event codes as reported on the result channel.
  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_ENTRY      = 3'd1,
    EV_EXIT       = 3'd2,
    EV_PAIR_OUT   = 3'd3,
    EV_PAIR_IN    = 3'd4,
    EV_OUTER_ONLY = 3'd5,
    EV_INNER_ONLY = 3'd6
  } passage_event_e;

  // Highest event code that can appear.
  localparam logic [2:0] EventMax = EV_INNER_ONLY;

  // One sensor sample.
  typedef struct packed {
    logic inner_door_open;
    logic outer_door_open;
  } in_item_t;

  // One classification result.
  typedef struct packed {
    logic [2:0] passage_event;
    logic       inner_led;
    logic       outer_led;
  } out_item_t;

endpackage

// ===== src/double_door_passage_classifier_unit.sv =====
// Double door passage classifier, top level.
// Input register, then result register; a stalled result holds the staged item.
// Throughput: one item per cycle unless the output stalls; one state step per item.
// Reset (rst_ni low, asynchronous): pipeline empty, doors closed, no races, recording on.
// Depends on dd_pkg and dd_track.
module double_door_passage_classifier_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dd_pkg::in_item_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dd_pkg::out_item_t out_item_o
);

  logic              record_enable_q;
  logic              stg_valid_q, stg_valid_d;
  dd_pkg::in_item_t  stg_item_q;
  logic              out_valid_q, out_valid_d;
  dd_pkg::out_item_t out_item_q, out_item_d;
  logic              advance;
  logic              in_accept;
  logic [2:0]        event_code;

  // Configuration register, always writable.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      record_enable_q <= 1'b1;
    end else if (cfg_valid_i) begin
      record_enable_q <= cfg_data_i;
    end
  end

  // Handshake: the staged item moves on whenever the result register frees up.
  assign advance    = stg_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !stg_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    stg_valid_d = stg_valid_q;
    if (in_accept) begin
      stg_valid_d = 1'b1;
    end else if (advance) begin
      stg_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      stg_item_q <= in_item_i;
    end
  end

  // Tracking and classification of the staged item.
  dd_track u_track (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .sample_i        (stg_item_q),
    .record_enable_i (record_enable_q),
    .passage_event_o (event_code)
  );

  // Result register.
  always_comb begin
    out_item_d.passage_event = event_code;
    out_item_d.inner_led     = stg_item_q.inner_door_open;
    out_item_d.outer_led     = stg_item_q.outer_door_open;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== src/dd_track.sv =====
// Door tracking state and passage classification for one sample per step.
// Depends on dd_pkg for the status, race and event encodings.
module dd_track (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  dd_pkg::in_item_t sample_i,
  input  logic             record_enable_i,
  output logic [2:0]       passage_event_o
);

  dd_pkg::door_status_e inner_status_q, inner_status_d;
  dd_pkg::door_status_e outer_status_q, outer_status_d;
  dd_pkg::door_who_e    first_opened_q, first_opened_d;
  dd_pkg::door_who_e    first_closed_q, first_closed_d;

  dd_pkg::door_status_e inner_st, outer_st;
  dd_pkg::door_who_e    fo_mid, fc_mid, fo_new, fc_new;
  dd_pkg::passage_event_e event_cls;
  logic                 complete;

  // Inner door is evaluated first, then the outer door sees its updates.
  always_comb begin
    inner_st = inner_status_q;
    fo_mid   = first_opened_q;
    fc_mid   = first_closed_q;
    if (sample_i.inner_door_open) begin
      inner_st = dd_pkg::ST_OPEN;
      if (fo_mid == dd_pkg::WHO_NONE) fo_mid = dd_pkg::WHO_INNER;
    end else if (inner_status_q == dd_pkg::ST_OPEN) begin
      inner_st = dd_pkg::ST_WAS_OPEN;
      if (fc_mid == dd_pkg::WHO_NONE) fc_mid = dd_pkg::WHO_INNER;
    end

    outer_st = outer_status_q;
    fo_new   = fo_mid;
    fc_new   = fc_mid;
    if (sample_i.outer_door_open) begin
      outer_st = dd_pkg::ST_OPEN;
      if (fo_new == dd_pkg::WHO_NONE) fo_new = dd_pkg::WHO_OUTER;
    end else if (outer_status_q == dd_pkg::ST_OPEN) begin
      outer_st = dd_pkg::ST_WAS_OPEN;
      if (fc_new == dd_pkg::WHO_NONE) fc_new = dd_pkg::WHO_OUTER;
    end
  end

  // A passage is complete once a closure was seen and neither door is open.
  assign complete = (fc_new != dd_pkg::WHO_NONE) &&
                    (inner_st != dd_pkg::ST_OPEN) &&
                    (outer_st != dd_pkg::ST_OPEN);

  // Classify from the order of openings and closings.
  always_comb begin
    if (inner_st == dd_pkg::ST_WAS_OPEN) begin
      if (outer_st == dd_pkg::ST_WAS_OPEN) begin
        if (fo_new == dd_pkg::WHO_OUTER) begin
          event_cls = (fc_new == dd_pkg::WHO_OUTER) ? dd_pkg::EV_ENTRY
                                                    : dd_pkg::EV_PAIR_OUT;
        end else begin
          event_cls = (fc_new == dd_pkg::WHO_OUTER) ? dd_pkg::EV_PAIR_IN
                                                    : dd_pkg::EV_EXIT;
        end
      end else begin
        event_cls = dd_pkg::EV_INNER_ONLY;
      end
    end else begin
      event_cls = dd_pkg::EV_OUTER_ONLY;
    end
  end

  assign passage_event_o = (complete && record_enable_i) ? event_cls : dd_pkg::EV_NONE;

  // Next state: all tracking is cleared when a passage completes.
  always_comb begin
    if (complete) begin
      inner_status_d = dd_pkg::ST_CLOSED;
      outer_status_d = dd_pkg::ST_CLOSED;
      first_opened_d = dd_pkg::WHO_NONE;
      first_closed_d = dd_pkg::WHO_NONE;
    end else begin
      inner_status_d = inner_st;
      outer_status_d = outer_st;
      first_opened_d = fo_new;
      first_closed_d = fc_new;
    end
  end

  // State registers advance only when the sample is consumed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_status_q <= dd_pkg::ST_CLOSED;
      outer_status_q <= dd_pkg::ST_CLOSED;
      first_opened_q <= dd_pkg::WHO_NONE;
      first_closed_q <= dd_pkg::WHO_NONE;
    end else if (step_i) begin
      inner_status_q <= inner_status_d;
      outer_status_q <= outer_status_d;
      first_opened_q <= first_opened_d;
      first_closed_q <= first_closed_d;
    end
  end

endmodule

// ===== src/dd_checker.sv =====
// Port-level checks for the double door passage classifier, bound to the top level.
// Depends on dd_pkg and double_door_passage_classifier_unit.
module dd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input dd_pkg::out_item_t out_item_o
);

  // A result item stays offered until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped before it was taken");

  // A stalled result item keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("result item changed while stalled");

  // Event codes stay within the defined set.
  a_event_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.passage_event <= dd_pkg::EventMax)
    else $error("passage event code out of range");

  // A passage only completes on a sample with both doors closed.
  a_event_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.passage_event != dd_pkg::EV_NONE) |->
      !out_item_o.inner_led && !out_item_o.outer_led)
    else $error("passage reported while a door is open");

endmodule

bind double_door_passage_classifier_unit dd_checker u_dd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

// ===== tb/sv/double_door_passage_classifier_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the double door passage classifier top level.
// Depends on dd_pkg and double_door_passage_classifier_unit; nothing else.
module double_door_passage_classifier_unit_tb;

  // Pause after the last result before a register write or the end of the run.
  localparam int LatencyCycles = 4;
  // Cycles in which no channel moves an item before the run is declared hung.
  localparam int StallLimit = 2000;
  // Mismatch lines beyond this count are counted but not printed.
  localparam int PrintLimit = 200;
  localparam int PhaseSamples = 450;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_data = 1'b0;
  logic              cfg_ready_o;
  logic              in_valid = 1'b0;
  dd_pkg::in_item_t  in_item = '0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic              out_ready = 1'b0;
  dd_pkg::out_item_t out_item_o;

  // Stimulus still to be driven and results still to arrive.
  dd_pkg::in_item_t  pending_samples[$];
  dd_pkg::out_item_t predicted_reports[$];

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  // Shadow of the classifier state and of the recording register.
  dd_pkg::door_status_e inner_state = dd_pkg::ST_CLOSED;
  dd_pkg::door_status_e outer_state = dd_pkg::ST_CLOSED;
  dd_pkg::door_who_e    opened_first = dd_pkg::WHO_NONE;
  dd_pkg::door_who_e    closed_first = dd_pkg::WHO_NONE;
  logic                 record_on = 1'b1;

  // Current position of the random sensor walk.
  logic walk_inner = 1'b0;
  logic walk_outer = 1'b0;

  double_door_passage_classifier_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Updates one door's status and claims the open and close races for it.
  function automatic dd_pkg::door_status_e advance_door(
    input logic                 open,
    input dd_pkg::door_status_e status,
    input dd_pkg::door_who_e    who
  );
    dd_pkg::door_status_e next_status;
    next_status = status;
    if (open) begin
      next_status = dd_pkg::ST_OPEN;
      if (opened_first == dd_pkg::WHO_NONE) opened_first = who;
    end else if (status == dd_pkg::ST_OPEN) begin
      if (closed_first == dd_pkg::WHO_NONE) closed_first = who;
      next_status = dd_pkg::ST_WAS_OPEN;
    end
    return next_status;
  endfunction

  // Advances the shadow state by one sample and returns the expected result.
  function automatic dd_pkg::out_item_t classify_sample(input dd_pkg::in_item_t sample);
    dd_pkg::passage_event_e ev;
    dd_pkg::out_item_t      res;
    ev = dd_pkg::EV_NONE;
    // The inner door is handled first, so it wins ties within one sample.
    inner_state = advance_door(sample.inner_door_open, inner_state, dd_pkg::WHO_INNER);
    outer_state = advance_door(sample.outer_door_open, outer_state, dd_pkg::WHO_OUTER);
    if (closed_first != dd_pkg::WHO_NONE && inner_state != dd_pkg::ST_OPEN &&
        outer_state != dd_pkg::ST_OPEN) begin
      if (inner_state == dd_pkg::ST_WAS_OPEN) begin
        if (outer_state == dd_pkg::ST_WAS_OPEN) begin
          if (opened_first == dd_pkg::WHO_OUTER) begin
            ev = (closed_first == dd_pkg::WHO_OUTER) ? dd_pkg::EV_ENTRY
                                                     : dd_pkg::EV_PAIR_OUT;
          end else begin
            ev = (closed_first == dd_pkg::WHO_OUTER) ? dd_pkg::EV_PAIR_IN
                                                     : dd_pkg::EV_EXIT;
          end
        end else begin
          ev = dd_pkg::EV_INNER_ONLY;
        end
      end else begin
        ev = dd_pkg::EV_OUTER_ONLY;
      end
      inner_state  = dd_pkg::ST_CLOSED;
      outer_state  = dd_pkg::ST_CLOSED;
      opened_first = dd_pkg::WHO_NONE;
      closed_first = dd_pkg::WHO_NONE;
    end
    // With recording off the passage is still consumed but not reported.
    if (!record_on) ev = dd_pkg::EV_NONE;
    res.passage_event = ev;
    res.inner_led     = sample.inner_door_open;
    res.outer_led     = sample.outer_door_open;
    return res;
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what);
    if (mismatch_count < PrintLimit) $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Sender: presents queued samples and predicts each one as it is accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) predicted_reports.push_back(classify_sample(in_item));
      if (!in_valid || in_ready_o) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_item  <= pending_samples.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls at random and checks every accepted result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        if (predicted_reports.size() == 0) begin
          report_mismatch($sformatf("unexpected result %p", out_item_o));
        end else begin
          dd_pkg::out_item_t want;
          want = predicted_reports.pop_front();
          if (out_item_o.passage_event !== want.passage_event)
            report_mismatch($sformatf("passage_event %0d, expected %0d",
                                      out_item_o.passage_event, want.passage_event));
          if (out_item_o.inner_led !== want.inner_led)
            report_mismatch($sformatf("inner_led %b, expected %b",
                                      out_item_o.inner_led, want.inner_led));
          if (out_item_o.outer_led !== want.outer_led)
            report_mismatch($sformatf("outer_led %b, expected %b",
                                      out_item_o.outer_led, want.outer_led));
        end
      end
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Watchdog on cycles in which no channel moves an item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o))
      begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic push_sample(input logic inner_open, input logic outer_open);
    dd_pkg::in_item_t s;
    s.inner_door_open = inner_open;
    s.outer_door_open = outer_open;
    pending_samples.push_back(s);
  endtask

  // Mostly a sticky random walk of both doors, with some fully random noise.
  task automatic queue_random_samples(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 10) begin
        walk_inner = 1'($urandom_range(1));
        walk_outer = 1'($urandom_range(1));
      end else begin
        if ($urandom_range(99) < 35) walk_inner = !walk_inner;
        if ($urandom_range(99) < 35) walk_outer = !walk_outer;
      end
      push_sample(walk_inner, walk_outer);
    end
  endtask

  // Blocks the stimulus sequence until every queued sample has its result.
  task automatic drain_all;
    @(posedge clk_i);
    while (pending_samples.size() != 0 || in_valid || predicted_reports.size() != 0)
      @(posedge clk_i);
    repeat (LatencyCycles) @(posedge clk_i);
  endtask

  task automatic write_record_enable(input logic value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    record_on = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input logic rec_value);
    sender_idle_pct    = send_pct;
    receiver_stall_pct = recv_pct;
    write_record_enable(rec_value);
    queue_random_samples(PhaseSamples / 2);
    // Let the pipeline run dry once in the middle of the phase.
    drain_all();
    queue_random_samples(PhaseSamples - PhaseSamples / 2);
    drain_all();
  endtask

  // Stimulus sequence: reset, directed passages, then three random phases.
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    sender_idle_pct    = 18;
    receiver_stall_pct = 70;
    write_record_enable(1'b1);
    // Idle sample, then entry: outer opens first and closes first.
    push_sample(1'b0, 1'b0);
    push_sample(1'b0, 1'b1); push_sample(1'b1, 1'b1); push_sample(1'b1, 1'b0);
    push_sample(1'b0, 1'b0);
    // Exit: inner opens first and closes first.
    push_sample(1'b1, 1'b0); push_sample(1'b1, 1'b1); push_sample(1'b0, 1'b1);
    push_sample(1'b0, 1'b0);
    // Pair from outside and pair from inside.
    push_sample(1'b0, 1'b1); push_sample(1'b1, 1'b1); push_sample(1'b0, 1'b1);
    push_sample(1'b0, 1'b0);
    push_sample(1'b1, 1'b0); push_sample(1'b1, 1'b1); push_sample(1'b1, 1'b0);
    push_sample(1'b0, 1'b0);
    // Outer only, inner only, and both doors moving in the same sample.
    push_sample(1'b0, 1'b1); push_sample(1'b0, 1'b0);
    push_sample(1'b1, 1'b0); push_sample(1'b0, 1'b0);
    push_sample(1'b1, 1'b1); push_sample(1'b0, 1'b0);
    drain_all();

    run_phase(18, 70, 1'b1);
    run_phase(70, 18, 1'b0);
    run_phase(0, 0, 1'b1);

    if (predicted_reports.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", predicted_reports.size()));
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/dd_pkg.sv
src/dd_track.sv
src/double_door_passage_classifier_unit.sv
src/dd_checker.sv
tb/sv/double_door_passage_classifier_unit_tb.sv
